>>> sv/udc_pkg.sv
// Package for the UART baud divisor calculator: request, result, stage and
// configuration types, widths and constants. No dependencies.
package udc_pkg;

  localparam int CLK_W  = 27;
  localparam int BAUD_W = 25;
  localparam int DINT_W = 16;
  localparam int FRAC_W = 6;
  localparam int BOUT_W = 30;
  localparam int N_W    = 31;
  localparam int REM_W  = BAUD_W;
  localparam int VAL_W  = DINT_W + FRAC_W;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 27'd16000000;

  // Thresholds on floor(16 * clock / baud) for divisor limits at /8 and /16
  localparam logic [N_W-1:0] LIM_X8  = 31'd8388480;
  localparam logic [N_W-1:0] LIM_X16 = 31'd16776960;

  localparam logic ACT_FWD = 1'b0;
  localparam logic ACT_REV = 1'b1;

  localparam logic REG_CLOCK_HZ = 1'b0;
  localparam logic REG_SMART    = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BAUD_W-1:0] baud_rate;
    logic [DINT_W-1:0] divisor_integer;
    logic [FRAC_W-1:0] divisor_fraction;
    logic              high_speed_in;
  } udc_req_t;

  typedef struct packed {
    logic [DINT_W-1:0] integer_part;
    logic [FRAC_W-1:0] fraction_part;
    logic              high_speed_out;
    logic              out_of_range;
    logic [BOUT_W-1:0] baud_out;
  } udc_res_t;

  typedef struct packed {
    logic              action;
    logic              zero_div;
    logic [REM_W-1:0]  den;
    logic [REM_W-1:0]  rem;
    logic [N_W-1:0]    nq;
  } udc_stage_t;

  typedef struct packed {
    logic [CLK_W-1:0] clock_hz;
    logic             smart_mode;
  } udc_cfg_t;

endpackage

>>> sv/udc_cfg.sv
// Configuration registers of the UART baud divisor calculator on an APB-style port.
// Depends on udc_pkg.
module udc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [udc_pkg::ADDR_W-1:0] paddr,
  input  logic [udc_pkg::DATA_W-1:0] pwdata,
  output logic [udc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output udc_pkg::udc_cfg_t          cfg
);

  logic [udc_pkg::CLK_W-1:0] clock_hz_r;
  logic                      smart_mode_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r   <= udc_pkg::CLOCK_HZ_RST;
      smart_mode_r <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        udc_pkg::REG_CLOCK_HZ: clock_hz_r   <= pwdata[udc_pkg::CLK_W-1:0];
        udc_pkg::REG_SMART:    smart_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      udc_pkg::REG_CLOCK_HZ:
        prdata = {{(udc_pkg::DATA_W-udc_pkg::CLK_W){1'b0}}, clock_hz_r};
      udc_pkg::REG_SMART:
        prdata = {{(udc_pkg::DATA_W-1){1'b0}}, smart_mode_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.clock_hz   = clock_hz_r;
  assign cfg.smart_mode = smart_mode_r;

endmodule

>>> sv/udc_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered toward the next cell.
// Depends on udc_pkg.
module udc_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  udc_pkg::udc_stage_t stg_i,
  output logic                vld_o,
  output udc_pkg::udc_stage_t stg_o
);

  logic [udc_pkg::REM_W:0] trial;
  logic [udc_pkg::REM_W:0] diff;
  logic                    ge;
  udc_pkg::udc_stage_t     stg_nxt;
  udc_pkg::udc_stage_t     stg_r;
  logic                    vld_r;

  assign trial = {stg_i.rem, stg_i.nq[udc_pkg::N_W-1]};
  assign diff  = trial - {1'b0, stg_i.den};
  assign ge    = (trial >= {1'b0, stg_i.den});

  always_comb begin
    stg_nxt     = stg_i;
    stg_nxt.rem = ge ? diff[udc_pkg::REM_W-1:0] : trial[udc_pkg::REM_W-1:0];
    stg_nxt.nq  = {stg_i.nq[udc_pkg::N_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

>>> sv/udc_result.sv
// Result stage: range checks, rounding, /8 or /16 selection, reverse-mode baud output and the output register.
// Depends on udc_pkg.
module udc_result (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  udc_pkg::udc_stage_t stg_i,
  input  logic                smart_mode,
  output logic                out_strobe,
  output udc_pkg::udc_res_t   out_res
);

  logic [udc_pkg::N_W-1:0]   quo;
  logic                      rem_nz;
  logic                      over16;
  logic                      use16;
  logic [udc_pkg::N_W:0]     q8_inc;
  logic [udc_pkg::N_W-1:0]   q16_inc;
  logic [udc_pkg::VAL_W-1:0] v8;
  logic [udc_pkg::VAL_W-1:0] v16;
  udc_pkg::udc_res_t         res_nxt;
  udc_pkg::udc_res_t         res_r;
  logic                      strobe_r;

  assign quo     = stg_i.nq;
  assign rem_nz  = (stg_i.rem != '0);
  assign over16  = (quo > udc_pkg::LIM_X16) || ((quo == udc_pkg::LIM_X16) && rem_nz);
  assign use16   = smart_mode || (quo > udc_pkg::LIM_X8) ||
                   ((quo == udc_pkg::LIM_X8) && rem_nz);
  assign q8_inc  = {1'b0, quo} + {{udc_pkg::N_W{1'b0}}, 1'b1};
  assign q16_inc = {1'b0, quo[udc_pkg::N_W-1:1]} + {{(udc_pkg::N_W-1){1'b0}}, 1'b1};
  assign v8      = q8_inc[udc_pkg::VAL_W:1];
  assign v16     = q16_inc[udc_pkg::VAL_W:1];

  always_comb begin
    res_nxt = '0;
    if (stg_i.action == udc_pkg::ACT_FWD) begin
      if (stg_i.zero_div || over16) begin
        res_nxt.out_of_range = 1'b1;
      end else if (use16 || (v16[udc_pkg::FRAC_W-1:0] < v8[udc_pkg::FRAC_W-1:0])) begin
        res_nxt.integer_part  = v16[udc_pkg::VAL_W-1:udc_pkg::FRAC_W];
        res_nxt.fraction_part = v16[udc_pkg::FRAC_W-1:0];
      end else begin
        res_nxt.integer_part   = v8[udc_pkg::VAL_W-1:udc_pkg::FRAC_W];
        res_nxt.fraction_part  = v8[udc_pkg::FRAC_W-1:0];
        res_nxt.high_speed_out = 1'b1;
      end
    end else if (!stg_i.zero_div) begin
      res_nxt.baud_out = quo[udc_pkg::BOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

>>> sv/uart_baud_divisor_calculator.sv
// UART baud divisor calculator: forward (baud to divisor) and reverse (divisor to baud).
// One request per cycle, busy never rises; out_strobe is registered in the result stage.
// Rate is set by a row of 31 restoring-division cells, one quotient bit each.
// Synchronous reset clears the pipeline valid bits and loads clock_hz 16000000, smart_mode 0.
// Depends on udc_pkg, udc_cfg, udc_div_cell, udc_result.
module uart_baud_divisor_calculator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  udc_pkg::udc_req_t          in_req,
  output logic                       out_strobe,
  output udc_pkg::udc_res_t          out_res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [udc_pkg::ADDR_W-1:0] paddr,
  input  logic [udc_pkg::DATA_W-1:0] pwdata,
  output logic [udc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  udc_pkg::udc_cfg_t   cfg;
  udc_pkg::udc_stage_t stg_w [udc_pkg::N_W+1];
  logic                vld_w [udc_pkg::N_W+1];
  udc_pkg::udc_stage_t stg_in;
  logic [udc_pkg::REM_W-1:0] rev_den;

  udc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy    = 1'b0;
  assign rev_den = {{(udc_pkg::REM_W-udc_pkg::VAL_W){1'b0}},
                    in_req.divisor_integer, in_req.divisor_fraction};

  always_comb begin
    stg_in.action = in_req.action;
    stg_in.rem    = '0;
    if (in_req.action == udc_pkg::ACT_FWD) begin
      stg_in.den = in_req.baud_rate;
      stg_in.nq  = {cfg.clock_hz, 4'b0000};
    end else begin
      stg_in.den = rev_den;
      stg_in.nq  = in_req.high_speed_in ? {1'b0, cfg.clock_hz, 3'b000}
                                        : {2'b00, cfg.clock_hz, 2'b00};
    end
    stg_in.zero_div = (stg_in.den == '0);
  end

  assign vld_w[0] = start & ~busy;
  assign stg_w[0] = stg_in;

  for (genvar i = 0; i < udc_pkg::N_W; i++) begin : g_cell
    udc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_w[i]),
      .stg_i (stg_w[i]),
      .vld_o (vld_w[i+1]),
      .stg_o (stg_w[i+1])
    );
  end

  udc_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld_w[udc_pkg::N_W]),
    .stg_i      (stg_w[udc_pkg::N_W]),
    .smart_mode (cfg.smart_mode),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
